@@ rtl/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg
// Shared types, layout codes and channel expansion helpers for the packed
// pixel to RGB888 converter.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned MODE_W = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [MODE_W-1:0] mode_t;

  // Layout codes held in the mode register
  localparam mode_t MODE_RGB332  = 4'd0;
  localparam mode_t MODE_RGB565  = 4'd1;
  localparam mode_t MODE_RGBA444 = 4'd2;
  localparam mode_t MODE_BGRA444 = 4'd3;
  localparam mode_t MODE_ARGB444 = 4'd4;
  localparam mode_t MODE_ABGR444 = 4'd5;
  localparam mode_t MODE_RGBA555 = 4'd6;
  localparam mode_t MODE_BGRA555 = 4'd7;
  localparam mode_t MODE_ARGB555 = 4'd8;
  localparam mode_t MODE_ABGR555 = 4'd9;

  localparam mode_t MODE_RESET = MODE_RGB565;

  // Red in the lowest bits, blue in the highest
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  function automatic chan_t exp2(input logic [1:0] f);
    return {f, f, f, f};
  endfunction

  // floor(f * 255 / 7)
  function automatic chan_t exp3(input logic [2:0] f);
    chan_t e;
    case (f)
      3'd0:    e = 8'd0;
      3'd1:    e = 8'd36;
      3'd2:    e = 8'd72;
      3'd3:    e = 8'd109;
      3'd4:    e = 8'd145;
      3'd5:    e = 8'd182;
      3'd6:    e = 8'd218;
      default: e = 8'd255;
    endcase
    return e;
  endfunction

  function automatic chan_t exp4(input logic [3:0] f);
    return {f, f};
  endfunction

  // floor(f * 255 / 31) = 8f + floor(7f / 31)
  function automatic chan_t exp5(input logic [4:0] f);
    logic [2:0] corr;
    corr = 3'd0;
    if (f == 5'd31) begin
      corr = 3'd7;
    end else if (f >= 5'd27) begin
      corr = 3'd6;
    end else if (f >= 5'd23) begin
      corr = 3'd5;
    end else if (f >= 5'd18) begin
      corr = 3'd4;
    end else if (f >= 5'd14) begin
      corr = 3'd3;
    end else if (f >= 5'd9) begin
      corr = 3'd2;
    end else if (f >= 5'd5) begin
      corr = 3'd1;
    end
    return {f, 3'b000} + {5'd0, corr};
  endfunction

  // floor(f * 255 / 63) = 4f + floor(f / 21)
  function automatic chan_t exp6(input logic [5:0] f);
    logic [1:0] corr;
    corr = 2'd0;
    if (f == 6'd63) begin
      corr = 2'd3;
    end else if (f >= 6'd42) begin
      corr = 2'd2;
    end else if (f >= 6'd21) begin
      corr = 2'd1;
    end
    return {f, 2'b00} + {6'd0, corr};
  endfunction

endpackage

@@ rtl/ppr_expand.sv @@
// ----------------------------------------------------------------------------
// ppr_expand
// Field extraction and 8-bit expansion of one packed pixel for the selected
// layout.
// ----------------------------------------------------------------------------
module ppr_expand (
  input  ppr_pkg::mode_t mode,
  input  ppr_pkg::word_t word,
  output ppr_pkg::rgb_t  pix
);
  import ppr_pkg::*;

  chan_t r;
  chan_t g;
  chan_t b;
  logic  swap;

  always_comb begin
    r    = '0;
    g    = '0;
    b    = '0;
    swap = 1'b0;
    case (mode)
      MODE_RGB332: begin
        r = exp3(word[7:5]);
        g = exp3(word[4:2]);
        b = exp2(word[1:0]);
      end
      MODE_RGB565: begin
        r = exp5(word[15:11]);
        g = exp6(word[10:5]);
        b = exp5(word[4:0]);
      end
      MODE_RGBA444, MODE_BGRA444: begin
        r    = exp4(word[15:12]);
        g    = exp4(word[11:8]);
        b    = exp4(word[7:4]);
        swap = (mode == MODE_BGRA444);
      end
      MODE_ARGB444, MODE_ABGR444: begin
        r    = exp4(word[11:8]);
        g    = exp4(word[7:4]);
        b    = exp4(word[3:0]);
        swap = (mode == MODE_ABGR444);
      end
      MODE_RGBA555, MODE_BGRA555: begin
        // green taken from bits 10:8 and 6:5, blue overlaps it at bit 5
        r    = exp5(word[15:11]);
        g    = exp5({word[10:8], word[6:5]});
        b    = exp5(word[5:1]);
        swap = (mode == MODE_BGRA555);
      end
      MODE_ARGB555, MODE_ABGR555: begin
        r    = exp5(word[14:10]);
        g    = exp5({word[9:8], word[7:5]});
        b    = exp5(word[4:0]);
        swap = (mode == MODE_ABGR555);
      end
      default: begin
        // unused codes give black
        r = '0;
        g = '0;
        b = '0;
      end
    endcase
  end

  assign pix.red   = swap ? b : r;
  assign pix.green = g;
  assign pix.blue  = swap ? r : b;

endmodule

@@ rtl/packed_pixel_to_rgb888_core.sv @@
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888_core
// Packed pixel (RGB332 / RGB565 / 4444 / 5551) to RGB888 stream converter.
// ----------------------------------------------------------------------------
// Usage:
//   Packed pixels arrive on the in_ stream, one 16-bit word per transfer.
//   Each word gives one RGB888 transfer on the out_ stream, in order.
//   cfg_we/cfg_wdata write the 4-bit layout register; write it only while
//   the stream is drained. Reset selects RGB565.
//   An input transfer is registered in the input register, then passes
//   through the expansion logic into the result register.
//   Throughput: one pixel per clock while out_tready holds; the two-stage
//   register pipe advances the result stage on advance, the input on in_tready.
//   Reset (rst_n low, synchronous) empties both stages; the register
//   returns to RGB565.
//   When the receiver stalls the result register holds, the input stage
//   still takes one more word if it is empty, then in_tready drops until
//   out_tready returns. No transfer is lost or repeated.
//   Unused layout codes give black pixels.
// ----------------------------------------------------------------------------
module packed_pixel_to_rgb888_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  ppr_pkg::mode_t       cfg_wdata,   // [3:0] pixel_mode
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  ppr_pkg::word_t       in_tdata,    // [15:0] packed_word
  // output stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import ppr_pkg::*;

  mode_t mode_r;
  logic  in_vld_r;
  word_t in_word_r;
  logic  out_vld_r;
  rgb_t  out_pix_r;

  rgb_t  pix_nxt;
  logic  advance;
  logic  in_xfer;

  // Hold the layout register; the user writes it only while the stream is drained, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Advance the pipe whenever the result register is free or being taken
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = advance || !in_vld_r;
  assign in_xfer   = in_tvalid && in_tready;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_word_r <= in_tdata;
    end
  end

  ppr_expand u_expand (
    .mode (mode_r),
    .word (in_word_r),
    .pix  (pix_nxt)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_pix_r <= pix_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_pix_r;

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the packed pixel to RGB888 converter. A behavioural
// predictor expands every accepted pixel under the current layout, and a
// monitor compares each output transfer, channel by channel, with the oldest
// prediction. Covers reset layout, every layout code including the unused
// ones, random traffic with sender gaps and receiver stalls, and a long
// receiver hold-off that fills the pipe and stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ppr_pkg::*;

  // Field maxima for the expansion floor(f * FULL / max)
  localparam int unsigned FULL = 255;
  localparam int unsigned MAX2 = 3;
  localparam int unsigned MAX3 = 7;
  localparam int unsigned MAX4 = 15;
  localparam int unsigned MAX5 = 31;
  localparam int unsigned MAX6 = 63;

  // Layout codes with no defined layout
  localparam mode_t MODE_UNUSED_LO = mode_t'(MODE_ABGR555 + 1);
  localparam mode_t MODE_UNUSED_HI = '1;

  localparam int unsigned TAIL_CYCLES = 8;    // pipe is two deep; allow slack
  localparam int unsigned HOLD_CYCLES = 150;  // long receiver hold-off

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  mode_t       cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  word_t       in_tdata;    // [15:0] packed_word
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [7:0] red, [15:8] green, [23:16] blue

  // Predictions waiting for their output transfer, oldest first
  rgb_t        pixel_q[$];
  mode_t       cur_mode;
  int unsigned err_count;
  int unsigned out_count;

  // Sender pacing
  bit          gaps_on;
  int unsigned burst_left;

  // Receiver controls, read by the stall process
  bit          stall_on;
  int unsigned hold_len;
  int unsigned hold_kick;

  packed_pixel_to_rgb888_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic chan_t scale_field(int unsigned f, int unsigned fmax);
    return chan_t'((f * FULL) / fmax);
  endfunction

  function automatic rgb_t rgb_from_word(mode_t m, word_t w);
    rgb_t  px;
    chan_t tmp;
    bit    swap_rb;
    px      = '0;
    swap_rb = 1'b0;
    case (m)
      MODE_RGB332: begin
        // top byte plays no part
        px.red   = scale_field(32'(w[7:5]), MAX3);
        px.green = scale_field(32'(w[4:2]), MAX3);
        px.blue  = scale_field(32'(w[1:0]), MAX2);
      end
      MODE_RGB565: begin
        px.red   = scale_field(32'(w[15:11]), MAX5);
        px.green = scale_field(32'(w[10:5]), MAX6);
        px.blue  = scale_field(32'(w[4:0]), MAX5);
      end
      MODE_RGBA444, MODE_BGRA444: begin
        px.red   = scale_field(32'(w[15:12]), MAX4);
        px.green = scale_field(32'(w[11:8]), MAX4);
        px.blue  = scale_field(32'(w[7:4]), MAX4);
        swap_rb  = (m == MODE_BGRA444);
      end
      MODE_ARGB444, MODE_ABGR444: begin
        px.red   = scale_field(32'(w[11:8]), MAX4);
        px.green = scale_field(32'(w[7:4]), MAX4);
        px.blue  = scale_field(32'(w[3:0]), MAX4);
        swap_rb  = (m == MODE_ABGR444);
      end
      MODE_RGBA555, MODE_BGRA555: begin
        // green takes bits 10:8 over 6:5; blue overlaps it at bit 5
        px.red   = scale_field(32'(w[15:11]), MAX5);
        px.green = scale_field(32'({w[10:8], w[6:5]}), MAX5);
        px.blue  = scale_field(32'(w[5:1]), MAX5);
        swap_rb  = (m == MODE_BGRA555);
      end
      MODE_ARGB555, MODE_ABGR555: begin
        px.red   = scale_field(32'(w[14:10]), MAX5);
        px.green = scale_field(32'({w[9:8], w[7:5]}), MAX5);
        px.blue  = scale_field(32'(w[4:0]), MAX5);
        swap_rb  = (m == MODE_ABGR555);
      end
      default: ;  // unused codes give black
    endcase
    if (swap_rb) begin
      tmp      = px.red;
      px.red   = px.blue;
      px.blue  = tmp;
    end
    return px;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and output monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch at output %0d: %s got %0d expected %0d",
             out_count, what, got, want);
    err_count++;
  endtask

  // Sample at the edge; values read here are those the block saw
  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rgb_t'(out_tdata);
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected transfer, data", 32'(out_tdata), 0);
      end else begin
        want = pixel_q.pop_front();
        if (got.red   !== want.red)
          report_mismatch("red",   32'(got.red),   32'(want.red));
        if (got.green !== want.green)
          report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue  !== want.blue)
          report_mismatch("blue",  32'(got.blue),  32'(want.blue));
      end
      out_count++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rx_stall
    int unsigned seen;
    int unsigned hold_cnt;
    logic [7:0]  pat;
    int unsigned step;
    seen     = 0;
    hold_cnt = 0;
    pat      = 8'hFF;
    step     = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kick != seen) begin
        seen     = hold_kick;
        hold_cnt = hold_len;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!stall_on) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= pat[step];
        step = (step + 1) % 8;
        // keep at least one ready slot per pattern so traffic always moves
        if (step == 0) pat = 8'($urandom_range(0, 255)) | 8'h01;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared sender and configuration helpers
  // --------------------------------------------------------------------------
  // Offer one pixel, hold it until taken, then record its prediction
  task automatic send_pixel(input word_t w);
    if (gaps_on && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixel_q.push_back(rgb_from_word(cur_mode, w));
    if (burst_left != 0) burst_left--;
  endtask

  // Drop valid and wait for every outstanding pixel to come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // Write the layout register, only with the pipe empty
  task automatic set_mode(input mode_t m);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
  endtask

  function automatic word_t rand_word();
    // mostly uniform, with a share of all-zero and all-one words
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return word_t'($urandom_range(0, 16'hFFFF));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // No write yet: the reset layout must be RGB565
  task automatic test_reset_layout();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF81F);
    send_pixel(16'h07E0);
  endtask

  // Short directed pass over every layout and the odd corners
  task automatic test_layouts();
    set_mode(MODE_RGB332);
    send_pixel(16'hFF00);   // upper byte ignored
    send_pixel(16'h00FF);
    send_pixel(16'h00B6);
    set_mode(MODE_RGBA444);  send_pixel(16'hA5C3);
    set_mode(MODE_BGRA444);  send_pixel(16'hA5C3);
    set_mode(MODE_ARGB444);  send_pixel(16'h5A3C);
    set_mode(MODE_ABGR444);  send_pixel(16'h5A3C);
    set_mode(MODE_RGBA555);
    send_pixel(16'h0760);   // green bits only, shared bit 5
    send_pixel(16'h0090);   // bits the green field skips
    set_mode(MODE_BGRA555);  send_pixel(16'hF83E);
    set_mode(MODE_ARGB555);
    send_pixel(16'h03E0);
    send_pixel(16'h7C1F);
    set_mode(MODE_ABGR555);  send_pixel(16'hFFFF);
    set_mode(MODE_UNUSED_LO); send_pixel(16'hFFFF);
    set_mode(MODE_UNUSED_HI); send_pixel(16'hFFFF);
  endtask

  // Random pixels, one phase per layout code plus two on random defined layouts, pacing varied per phase
  task automatic test_random_traffic();
    mode_t m;
    for (int p = 0; p < 18; p++) begin
      m = (p < 16) ? mode_t'(p) : mode_t'($urandom_range(MODE_RGB332, MODE_ABGR555));
      set_mode(m);
      // every third phase runs flat out, no gaps and no stalls
      gaps_on  = (p % 3 != 0);
      stall_on = (p % 3 != 0);
      repeat ($urandom_range(40, 60)) send_pixel(rand_word());
    end
  endtask

  // Hold the receiver off for a long time while the sender keeps offering
  task automatic test_backpressure();
    set_mode(MODE_RGB565);
    gaps_on   = 1'b0;
    stall_on  = 1'b0;
    hold_len  = HOLD_CYCLES;
    hold_kick = hold_kick + 1;
    repeat (30) send_pixel(rand_word());
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    set_mode(MODE_ARGB555);
    repeat (20) send_pixel(rand_word());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    err_count  = 0;
    out_count  = 0;
    cur_mode   = MODE_RESET;
    gaps_on    = 1'b1;
    burst_left = 0;
    stall_on   = 1'b1;
    hold_len   = 0;
    hold_kick  = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= MODE_RESET;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_layout();
    test_layouts();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) begin
      report_mismatch("missing outputs, count", 0, unsigned'(pixel_q.size()));
    end
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ packed_pixel_to_rgb888_core.f @@
rtl/ppr_pkg.sv
rtl/ppr_expand.sv
rtl/packed_pixel_to_rgb888_core.sv
dv/tb.sv
